// ===== hdl/mbcs_pkg.sv =====
// shared types, constants and functions of the belt command sequencer
package mbcs_pkg;

  localparam int KIND_W   = 2;
  localparam int SPEED_W  = 11;
  localparam int BYTE_W   = 8;
  localparam int BELT_W   = 2;
  localparam int VALUE_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int OFFSET_W = 20;
  localparam int ADDR_W   = 8;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPEED = 2'd2;

  localparam logic [1:0] REG_SLAVE  = 2'd0;
  localparam logic [1:0] REG_GAIN   = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;

  localparam logic [ADDR_W-1:0]   SLAVE_RESET  = 8'd1;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd2983;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 20'd9806;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [BELT_W-1:0] LAST_BELT = 2'd2;
  localparam logic [2:0]        LAST_BYTE = 3'd7;

  // floor(x / 100) = (x * RECIP) >> RECIP_SHIFT for x below 2^28
  localparam int PROD_W  = GAIN_W + SPEED_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RECIP_W = 29;
  localparam int RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP = 29'd343597384;
  localparam int MUL_W   = SUM_W + RECIP_W;
  localparam int QUOT_W  = MUL_W - RECIP_SHIFT;

  typedef struct packed {
    logic               speed;
    logic [VALUE_W-1:0] value;
  } entry_t;

  function automatic logic [15:0] run_register(input logic [BELT_W-1:0] belt);
    logic [15:0] r;
    case (belt)
      2'd0:    r = 16'h039F;
      2'd1:    r = 16'h0395;
      2'd2:    r = 16'h03A9;
      default: r = 16'h039F;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/mbcs_if.sv =====
// command and frame byte channel interfaces
interface mbcs_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [mbcs_pkg::KIND_W-1:0]  kind;
  logic [mbcs_pkg::SPEED_W-1:0] speed_value;
  logic                        speed_valid;
  modport source (output valid, kind, speed_value, speed_valid, input ready);
  modport sink   (input valid, kind, speed_value, speed_valid, output ready);
endinterface

interface mbcs_byte_if;
  logic                       valid;
  logic                       ready;
  logic [mbcs_pkg::BYTE_W-1:0] frame_byte;
  logic [mbcs_pkg::BELT_W-1:0] belt_index;
  logic                       last_in_frame;
  logic                       last_of_run;
  modport source (output valid, frame_byte, belt_index, last_in_frame, last_of_run,
                  input ready);
  modport sink   (input valid, frame_byte, belt_index, last_in_frame, last_of_run,
                  output ready);
endinterface

// ===== hdl/modbus_belt_command_sequencer_unit.sv =====
// top level of the belt command sequencer with its register port
// the first frame byte passes the front stages, the queue and the back end registers
// throughput: back end serializes 24 bytes per command, one per cycle if rsp.ready is high
// three-stage front pipeline and two-entry queue take one command per cycle unless full
// reset: synchronous, clears all control state and loads the register defaults
// no clearing pass after reset, the block is ready in the cycle after rst falls
module modbus_belt_command_sequencer_unit (
  input  logic                           clk,
  input  logic                           rst,
  mbcs_cmd_if.sink                       cmd,
  mbcs_byte_if.source                    rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbcs_pkg::PADDR_W-1:0]   paddr,
  input  logic [mbcs_pkg::PDATA_W-1:0]   pwdata,
  output logic [mbcs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [mbcs_pkg::ADDR_W-1:0]   slave_address;
  logic [mbcs_pkg::GAIN_W-1:0]   speed_gain;
  logic [mbcs_pkg::OFFSET_W-1:0] speed_offset;
  logic [1:0]                    reg_sel;
  logic                          wr_en;

  mbcs_pkg::entry_t push_data;
  logic             push_valid;
  logic             push_ready;
  mbcs_pkg::entry_t pop_data;
  logic             pop_valid;
  logic             pop_ready;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= mbcs_pkg::SLAVE_RESET;
      speed_gain    <= mbcs_pkg::GAIN_RESET;
      speed_offset  <= mbcs_pkg::OFFSET_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        mbcs_pkg::REG_SLAVE:  slave_address <= pwdata[mbcs_pkg::ADDR_W-1:0];
        mbcs_pkg::REG_GAIN:   speed_gain    <= pwdata[mbcs_pkg::GAIN_W-1:0];
        mbcs_pkg::REG_OFFSET: speed_offset  <= pwdata[mbcs_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mbcs_pkg::REG_SLAVE:  prdata = {24'd0, slave_address};
      mbcs_pkg::REG_GAIN:   prdata = {16'd0, speed_gain};
      mbcs_pkg::REG_OFFSET: prdata = {12'd0, speed_offset};
      default:              prdata = '0;
    endcase
  end

  mbcs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .gain       (speed_gain),
    .offset     (speed_offset),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  mbcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  mbcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .pop_data      (pop_data),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .rsp           (rsp)
  );

endmodule

// ===== hdl/mbcs_front.sv =====
// front end: accepts commands, drops empty and undefined ones, computes the register value
module mbcs_front (
  input  logic                            clk,
  input  logic                            rst,
  mbcs_cmd_if.sink                        cmd,
  input  logic [mbcs_pkg::GAIN_W-1:0]     gain,
  input  logic [mbcs_pkg::OFFSET_W-1:0]   offset,
  output mbcs_pkg::entry_t                push_data,
  output logic                            push_valid,
  input  logic                            push_ready
);

  logic                            v1, v2, v3;
  logic [mbcs_pkg::KIND_W-1:0]     kind1, kind2, kind3;
  logic [mbcs_pkg::PROD_W-1:0]     prod1;
  logic [mbcs_pkg::SUM_W-1:0]      sum2;
  logic [mbcs_pkg::QUOT_W-1:0]     quot3;
  logic [mbcs_pkg::MUL_W-1:0]      mul;
  logic                            advance;
  logic                            keep;

  assign advance   = !v3 || push_ready;
  assign cmd.ready = advance;

  assign keep = (cmd.kind == mbcs_pkg::KIND_START) || (cmd.kind == mbcs_pkg::KIND_STOP) ||
                ((cmd.kind == mbcs_pkg::KIND_SPEED) && cmd.speed_valid);

  assign mul = {{mbcs_pkg::RECIP_W{1'b0}}, sum2} *
               {{mbcs_pkg::SUM_W{1'b0}}, mbcs_pkg::RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= cmd.valid && keep;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind1 <= cmd.kind;
      prod1 <= {{mbcs_pkg::GAIN_W{1'b0}}, cmd.speed_value} *
               {{mbcs_pkg::SPEED_W{1'b0}}, gain};
      kind2 <= kind1;
      sum2  <= {1'b0, prod1} + {{(mbcs_pkg::SUM_W - mbcs_pkg::OFFSET_W){1'b0}}, offset};
      kind3 <= kind2;
      quot3 <= mul[mbcs_pkg::MUL_W-1:mbcs_pkg::RECIP_SHIFT];
    end
  end

  always_comb begin
    push_data.speed = (kind3 == mbcs_pkg::KIND_SPEED);
    case (kind3)
      mbcs_pkg::KIND_START: push_data.value = 16'd1;
      mbcs_pkg::KIND_STOP:  push_data.value = 16'd0;
      default: begin
        if (|quot3[mbcs_pkg::QUOT_W-1:mbcs_pkg::VALUE_W]) begin
          push_data.value = 16'hFFFF;
        end else begin
          push_data.value = quot3[mbcs_pkg::VALUE_W-1:0];
        end
      end
    endcase
  end

  assign push_valid = v3;

endmodule

// ===== hdl/mbcs_queue.sv =====
// two-entry queue between front and back
module mbcs_queue (
  input  logic             clk,
  input  logic             rst,
  input  mbcs_pkg::entry_t push_data,
  input  logic             push_valid,
  output logic             push_ready,
  output mbcs_pkg::entry_t pop_data,
  output logic             pop_valid,
  input  logic             pop_ready
);

  mbcs_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/mbcs_back.sv =====
// back end: serializes three frames per command with running crc
module mbcs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mbcs_pkg::ADDR_W-1:0]   slave_address,
  input  mbcs_pkg::entry_t              pop_data,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  mbcs_byte_if.source                   rsp
);

  logic                          active;
  mbcs_pkg::entry_t              entry;
  logic [mbcs_pkg::BELT_W-1:0]   belt;
  logic [2:0]                    byte_cnt;
  logic [15:0]                   crc;
  logic [15:0]                   reg_addr;
  logic [7:0]                    cur_byte;
  logic                          step;
  logic                          end_frame;
  logic                          end_run;

  assign step      = active && (!rsp.valid || rsp.ready);
  assign end_frame = (byte_cnt == mbcs_pkg::LAST_BYTE);
  assign end_run   = end_frame && (belt == mbcs_pkg::LAST_BELT);
  assign pop_ready = !active || (step && end_run);
  assign reg_addr  = mbcs_pkg::run_register(belt) - {15'd0, entry.speed};

  always_comb begin
    case (byte_cnt)
      3'd0:    cur_byte = slave_address;
      3'd1:    cur_byte = mbcs_pkg::FUNC_WRITE_SINGLE;
      3'd2:    cur_byte = reg_addr[15:8];
      3'd3:    cur_byte = reg_addr[7:0];
      3'd4:    cur_byte = entry.value[15:8];
      3'd5:    cur_byte = entry.value[7:0];
      3'd6:    cur_byte = crc[7:0];
      default: cur_byte = crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      belt      <= '0;
      byte_cnt  <= '0;
      crc       <= mbcs_pkg::CRC_INIT;
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= step || (rsp.valid && !rsp.ready);
      if (step) begin
        byte_cnt  <= byte_cnt + 3'd1;
        if (end_frame) begin
          crc  <= mbcs_pkg::CRC_INIT;
          belt <= end_run ? '0 : belt + 2'd1;
        end else if (byte_cnt < 3'd6) begin
          crc <= mbcs_pkg::crc_feed(crc, cur_byte);
        end
      end
      if (pop_ready) begin
        active <= pop_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      entry <= pop_data;
    end
    if (step) begin
      rsp.frame_byte    <= cur_byte;
      rsp.belt_index    <= belt;
      rsp.last_in_frame <= end_frame;
      rsp.last_of_run   <= end_run;
    end
  end

endmodule

// ===== hdl/mbcs_checker.sv =====
// port-level checks of the frame byte channel, bound to the top level
module mbcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mbcs_pkg::BYTE_W-1:0]   frame_byte,
  input logic [mbcs_pkg::BELT_W-1:0]   belt_index,
  input logic                          last_in_frame,
  input logic                          last_of_run
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(belt_index) &&
      $stable(last_in_frame) && $stable(last_of_run))
    else $error("stalled frame byte changed");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> last_in_frame && (belt_index == mbcs_pkg::LAST_BELT))
    else $error("run end not on last byte of sorting frame");

  a_belt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> belt_index != 2'd3)
    else $error("belt index out of range");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind modbus_belt_command_sequencer_unit mbcs_checker u_mbcs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .frame_byte    (rsp.frame_byte),
  .belt_index    (rsp.belt_index),
  .last_in_frame (rsp.last_in_frame),
  .last_of_run   (rsp.last_of_run)
);
